// ===== sv/scan_corridor_clear_check_core_macros.svh =====
// Assertion shorthands used by the corridor check back end.
// Both expect clk and rst in scope.
`ifndef SCAN_CORRIDOR_CLEAR_CHECK_CORE_MACROS_SVH
`define SCAN_CORRIDOR_CLEAR_CHECK_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define SCC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SCC_ASSERT_STEP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scc_pkg.sv =====
package scc_pkg;

  // Defaults for the top level parameters
  localparam int MAX_BEAMS_DEF  = 2048;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH    = 4;

  // Sine below this (Q16) falls back to the max range test
  localparam logic [16:0] SIN_TINY = 17'd66;

  // Odd polynomial coefficients for sin over a quarter turn
  localparam logic [63:0] SINE_C1 = 64'd102944;
  localparam logic [63:0] SINE_C3 = 64'd42334;
  localparam logic [63:0] SINE_C5 = 64'd5223;
  localparam logic [63:0] SINE_C7 = 64'd307;
  localparam logic [63:0] SINE_C9 = 64'd10;

  // Register indexes
  localparam logic [2:0] REG_BOX_HALF_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CONE_MARGIN     = 3'd1;
  localparam logic [2:0] REG_CONE_HALF_ANGLE = 3'd2;
  localparam logic [2:0] REG_START_ANGLE     = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP      = 3'd4;
  localparam logic [2:0] REG_MAX_RANGE       = 3'd5;

  typedef struct packed {
    logic [15:0] box_half_width;
    logic [15:0] cone_margin;
    logic [14:0] cone_half_angle;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] max_range;
  } cfg_t;

  // What the back end has to do with a beam
  typedef enum logic [1:0] {
    TEST_NONE     = 2'd0,
    TEST_CONE_HIT = 2'd1,
    TEST_SIDE     = 2'd2
  } beam_test_t;

  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_CONE = 2'd1,
    ZONE_SIDE = 2'd2
  } zone_t;

  // Classified beam passed from front to back
  typedef struct packed {
    logic [10:0] beam;
    logic        last;
    beam_test_t  test;
    logic [15:0] range_mm;
  } beam_item_t;

  // |sin| in Q16 for x in Q16 quarter turns, capped at one
  function automatic logic [16:0] sine_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    x2 = (x * x) >> 16;
    p  = SINE_C9;
    p  = SINE_C7 - ((x2 * p) >> 16);
    p  = SINE_C5 - ((x2 * p) >> 16);
    p  = SINE_C3 - ((x2 * p) >> 16);
    p  = SINE_C1 - ((x2 * p) >> 16);
    s  = (x * p) >> 16;
    return (s > 64'd65536) ? 17'h10000 : s[16:0];
  endfunction

endpackage

// ===== sv/scc_if.sv =====
// Beam channel
interface scc_beam_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        range_valid;
  logic [15:0] heading;
  logic        last_beam;

  modport source(output valid, range_mm, range_valid, heading, last_beam, input ready);
  modport sink(input valid, range_mm, range_valid, heading, last_beam, output ready);
endinterface

// Result channel
interface scc_result_if;
  logic        valid;
  logic        ready;
  logic        path_clear;
  logic [10:0] block_beam;
  logic [1:0]  block_zone;

  modport source(output valid, path_clear, block_beam, block_zone, input ready);
  modport sink(input valid, path_clear, block_beam, block_zone, output ready);
endinterface

// ===== sv/scc_front.sv =====
module scc_front
  import scc_pkg::*;
#(
  parameter int MAX_BEAMS        = MAX_BEAMS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  localparam int CNT_W = $clog2(MAX_BEAMS),
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      range_mm,
  input  logic             range_valid,
  input  logic [15:0]      heading,
  input  logic             last_beam,
  output logic             out_valid,
  input  logic             out_ready,
  output beam_item_t       out_item,
  output logic [IDX_W-1:0] out_idx
);

  localparam int PW = 15 + IDX_W;

  logic [CNT_W-1:0]    beam_count;
  logic [CNT_W-1:0]    beam_count_next;
  logic [15:0]         beam_angle;
  logic [15:0]         angle;
  logic [15:0]         rel;
  logic [16:0]         mag;
  logic [14:0]         fold;
  logic [PW-1:0]       scaled;
  logic [CNT_W+10:0]   cnt_ext;
  logic                accept;

  assign in_ready  = out_ready;
  assign out_valid = in_valid;
  assign accept    = in_valid && out_ready;

  // Beam angle relative to heading, folded to a magnitude
  assign angle = (beam_count == '0) ? cfg.start_angle : beam_angle;
  assign rel   = angle - heading;
  assign mag   = rel[15] ? (17'h10000 - {1'b0, rel}) : {1'b0, rel};
  assign fold  = (mag > 17'd16384) ? 15'(17'd32768 - mag) : mag[14:0];

  // Nearest sine table step
  assign scaled  = PW'(fold) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
  assign out_idx = scaled[14 +: IDX_W];

  assign cnt_ext = {11'b0, beam_count};

  // Classify the beat
  always_comb begin
    out_item.beam     = cnt_ext[10:0];
    out_item.last     = last_beam;
    out_item.range_mm = range_mm;
    if (!range_valid || range_mm == '0) begin
      out_item.test = TEST_NONE;
    end else if (mag <= {2'b0, cfg.cone_half_angle}) begin
      out_item.test = (range_mm < cfg.cone_margin) ? TEST_CONE_HIT : TEST_NONE;
    end else begin
      out_item.test = TEST_SIDE;
    end
  end

  // Count saturates; the last beat starts a new scan
  always_comb begin
    if (last_beam) begin
      beam_count_next = '0;
    end else if (beam_count != CNT_W'(MAX_BEAMS - 1)) begin
      beam_count_next = beam_count + 1'b1;
    end else begin
      beam_count_next = beam_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_count <= '0;
      beam_angle <= '0;
    end else if (accept) begin
      beam_count <= beam_count_next;
      beam_angle <= angle + cfg.angle_step;
    end
  end

endmodule

// ===== sv/scc_fifo.sv =====
module scc_fifo
  import scc_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/scc_back.sv =====
`include "scan_corridor_clear_check_core_macros.svh"

module scc_back
  import scc_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  beam_item_t       in_item,
  input  logic [IDX_W-1:0] in_idx,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             path_clear,
  output logic [10:0]      block_beam,
  output logic [1:0]       block_zone
);

  // Sine ROM, one entry per table step including the quarter turn
  logic [16:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned X = (longint'(k) * 65536) / SINE_TABLE_DEPTH;
    assign rom[k] = sine_q16(64'(X));
  end

  logic        s1_valid;
  beam_item_t  s1_item;
  logic [16:0] s1_sin;
  logic        s2_valid;
  beam_item_t  s2_item;
  logic [32:0] s2_prod;
  logic        s2_tiny;

  logic        stall;
  logic        adv;
  logic        commit;
  logic        commit_last;
  logic        hit;
  zone_t       zone;

  logic        blocked;
  logic        blocked_next;
  logic [10:0] first_beam;
  logic [1:0]  first_zone;
  logic        out_clear;
  logic [10:0] out_beam;
  zone_t       out_zone;

  // A last beat cannot retire while the previous result still waits
  assign stall       = s2_valid && s2_item.last && out_valid && !out_ready;
  assign adv         = !stall;
  assign in_ready    = adv;
  assign commit      = s2_valid && adv;
  assign commit_last = commit && s2_item.last;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // ROM read, then multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= in_item;
      s1_sin  <= rom[in_idx];
      s2_item <= s1_item;
      s2_prod <= 33'(s1_item.range_mm) * 33'(s1_sin);
      s2_tiny <= (s1_sin < SIN_TINY);
    end
  end

  // Zone decision
  always_comb begin
    case (s2_item.test)
      TEST_NONE:     zone = ZONE_NONE;
      TEST_CONE_HIT: zone = ZONE_CONE;
      TEST_SIDE: begin
        if (s2_tiny) begin
          zone = (s2_item.range_mm < cfg.max_range) ? ZONE_SIDE : ZONE_NONE;
        end else begin
          zone = (s2_prod < {1'b0, cfg.box_half_width, 16'h0000}) ? ZONE_SIDE : ZONE_NONE;
        end
      end
      default:       zone = ZONE_NONE;
    endcase
  end

  assign hit = commit && !blocked && (zone != ZONE_NONE);

  always_comb begin
    if (commit_last) begin
      blocked_next = 1'b0;
    end else if (hit) begin
      blocked_next = 1'b1;
    end else begin
      blocked_next = blocked;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      blocked    <= 1'b0;
      first_beam <= '0;
      first_zone <= ZONE_NONE;
    end else begin
      blocked <= blocked_next;
      if (commit_last) begin
        first_beam <= '0;
        first_zone <= ZONE_NONE;
      end else if (hit) begin
        first_beam <= s2_item.beam;
        first_zone <= zone;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_last) begin
      if (blocked) begin
        out_clear <= 1'b0;
        out_beam  <= first_beam;
        out_zone  <= zone_t'(first_zone);
      end else if (hit) begin
        out_clear <= 1'b0;
        out_beam  <= s2_item.beam;
        out_zone  <= zone;
      end else begin
        out_clear <= 1'b1;
        out_beam  <= '0;
        out_zone  <= ZONE_NONE;
      end
    end
  end

  assign path_clear = out_clear;
  assign block_beam = out_beam;
  assign block_zone = out_zone;

  `SCC_ASSERT_STEP(a_last_gives_result, commit_last, out_valid, "last beat gave no result")
  `SCC_ASSERT_STEP(a_scan_restarts, commit_last, !blocked, "block state survived scan end")
  `SCC_ASSERT_STEP(a_block_sticky, blocked && !commit_last, blocked, "block dropped mid scan")
  `SCC_ASSERT_CLK(a_clear_fields, out_valid && out_clear |-> (out_zone == ZONE_NONE) && (out_beam == '0), "clear result carries a block")

endmodule

// ===== sv/scan_corridor_clear_check_core.sv =====
// Corridor clear check for one lidar scan. Beams stream in on the beam channel,
// one beat per clock sustained; each beat is classified against the cone and
// side box in the front end, queued, then finished in a three stage back end
// (sine ROM read, range times sine multiply, zone decision). The beat marked
// last_beam yields one result, registered after its zone decision. The input
// stalls only when the four entry queue fills, which needs a result waiting at
// the output while the next scan's last beat reaches the decision stage.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no beams are in flight. No clearing pass runs after
// reset.
module scan_corridor_clear_check_core
  import scc_pkg::*;
#(
  parameter int MAX_BEAMS        = MAX_BEAMS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  scc_beam_if.sink     beam,
  scc_result_if.source result
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QW    = $bits(beam_item_t) + IDX_W;

  cfg_t             cfg;
  logic             front_valid;
  logic             front_ready;
  beam_item_t       front_item;
  logic [IDX_W-1:0] front_idx;
  logic             q_valid;
  logic             q_ready;
  logic [QW-1:0]    q_data;
  beam_item_t       q_item;
  logic [IDX_W-1:0] q_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_half_width  <= 16'd300;
      cfg.cone_margin     <= 16'd300;
      cfg.cone_half_angle <= 15'd8192;
      cfg.start_angle     <= 16'd32768;
      cfg.angle_step      <= 16'd182;
      cfg.max_range       <= 16'd3500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_HALF_WIDTH:  cfg.box_half_width  <= cfg_data;
        REG_CONE_MARGIN:     cfg.cone_margin     <= cfg_data;
        REG_CONE_HALF_ANGLE: cfg.cone_half_angle <= cfg_data[14:0];
        REG_START_ANGLE:     cfg.start_angle     <= cfg_data;
        REG_ANGLE_STEP:      cfg.angle_step      <= cfg_data;
        REG_MAX_RANGE:       cfg.max_range       <= cfg_data;
        default: ;
      endcase
    end
  end

  scc_front #(
    .MAX_BEAMS       (MAX_BEAMS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (beam.valid),
    .in_ready   (beam.ready),
    .range_mm   (beam.range_mm),
    .range_valid(beam.range_valid),
    .heading    (beam.heading),
    .last_beam  (beam.last_beam),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_item   (front_item),
    .out_idx    (front_idx)
  );

  scc_fifo #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_data ({front_idx, front_item}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  assign q_item = q_data[$bits(beam_item_t)-1:0];
  assign q_idx  = q_data[QW-1:$bits(beam_item_t)];

  scc_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .in_idx    (q_idx),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .path_clear(result.path_clear),
    .block_beam(result.block_beam),
    .block_zone(result.block_zone)
  );

endmodule
